// File: sv/fbm_pkg.sv
// ----------------------------------------------------------------------------
// fbm_pkg
// Shared types, constants and helpers for the field block metric block.
// ----------------------------------------------------------------------------
package fbm_pkg;

  // Pixel and payload widths
  localparam int PIX_W    = 8;
  localparam int MAX_PIX  = 8;
  localparam int LINE_W   = PIX_W * MAX_PIX;
  localparam int KIND_W   = 2;
  localparam int SUM_W    = 15;
  localparam int LANE_W   = 10;   // comb term: two 9-bit differences summed
  localparam int VAR_SHIFT = 2;   // variation scale of four

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Parameter defaults
  localparam int BLOCK_WIDTH_DEF = 8;
  localparam int BLOCK_LINES_DEF = 4;

  typedef logic [KIND_W-1:0] kind_t;

  // Metric kinds
  localparam kind_t KIND_DIFF = 2'd0;
  localparam kind_t KIND_COMB = 2'd1;
  localparam kind_t KIND_VAR  = 2'd2;

  // Per-line control carried down the pipeline
  typedef struct packed {
    logic  first;
    logic  last;
    kind_t kind;
    logic  ident;
  } ctl_t;

  // Absolute difference of two 9-bit values
  function automatic logic [PIX_W:0] absdiff9(input logic [PIX_W:0] x,
                                              input logic [PIX_W:0] y);
    return (x > y) ? (x - y) : (y - x);
  endfunction

endpackage

// File: sv/fbm_if.sv
// ----------------------------------------------------------------------------
// fbm_if
// Valid/ready channels for field lines in and block metrics out.
// ----------------------------------------------------------------------------
interface fbm_in_if;
  logic                       valid;
  logic                       ready;
  fbm_pkg::kind_t             opcode;
  logic                       identical_fields;
  logic [fbm_pkg::LINE_W-1:0] a_line;
  logic [fbm_pkg::LINE_W-1:0] a_next_line;
  logic [fbm_pkg::LINE_W-1:0] b_above_line;
  logic [fbm_pkg::LINE_W-1:0] b_line;

  modport source (output valid, opcode, identical_fields, a_line, a_next_line,
                  b_above_line, b_line, input ready);
  modport sink   (input valid, opcode, identical_fields, a_line, a_next_line,
                  b_above_line, b_line, output ready);
endinterface

interface fbm_out_if;
  logic                      valid;
  logic                      ready;
  logic [fbm_pkg::SUM_W-1:0] metric;
  fbm_pkg::kind_t            kind;

  modport source (output valid, metric, kind, input ready);
  modport sink   (input valid, metric, kind, output ready);
endinterface

// File: sv/fbm_lane.sv
// ----------------------------------------------------------------------------
// fbm_lane
// Per-pixel metric term for one pixel column, registered.
// ----------------------------------------------------------------------------
module fbm_lane (
  input  logic                        clk,
  input  logic                        en,
  input  fbm_pkg::kind_t              kind,
  input  logic                        var_en,
  input  logic [fbm_pkg::PIX_W-1:0]   a_pix,
  input  logic [fbm_pkg::PIX_W-1:0]   an_pix,
  input  logic [fbm_pkg::PIX_W-1:0]   bu_pix,
  input  logic [fbm_pkg::PIX_W-1:0]   b_pix,
  output logic [fbm_pkg::LANE_W-1:0]  term
);
  import fbm_pkg::*;

  logic [PIX_W:0]  a2, b2, ub_sum, an_sum;
  logic [PIX_W:0]  comb_top, comb_bot;
  logic [LANE_W-1:0] term_next;

  // Form doubled pixels and neighbor sums
  assign a2     = {a_pix, 1'b0};
  assign b2     = {b_pix, 1'b0};
  assign ub_sum = {1'b0, bu_pix} + {1'b0, b_pix};
  assign an_sum = {1'b0, a_pix} + {1'b0, an_pix};
  assign comb_top = absdiff9(a2, ub_sum);
  assign comb_bot = absdiff9(b2, an_sum);

  // Select the term for this block's kind
  always_comb begin
    case (kind)
      KIND_DIFF: term_next = LANE_W'(absdiff9({1'b0, a_pix}, {1'b0, b_pix}));
      KIND_COMB: term_next = LANE_W'(comb_top) + LANE_W'(comb_bot);
      KIND_VAR:  term_next = var_en ?
                   LANE_W'(absdiff9({1'b0, a_pix}, {1'b0, an_pix})) : '0;
      default:   term_next = '0;
    endcase
  end

  // Hold the term for the merge stage
  always_ff @(posedge clk) begin
    if (en) begin
      term <= term_next;
    end
  end

endmodule

// File: sv/fbm_merge.sv
// ----------------------------------------------------------------------------
// fbm_merge
// Sums the lane terms of one line into a registered line total.
// ----------------------------------------------------------------------------
module fbm_merge #(
  parameter int BLOCK_WIDTH = fbm_pkg::BLOCK_WIDTH_DEF,
  localparam int TREE_W = fbm_pkg::LANE_W + $clog2(BLOCK_WIDTH)
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         en,
  input  logic                                         valid_in,
  input  fbm_pkg::ctl_t                                ctl_in,
  input  logic [BLOCK_WIDTH-1:0][fbm_pkg::LANE_W-1:0]  terms,
  output logic                                         valid,
  output fbm_pkg::ctl_t                                ctl,
  output logic [TREE_W-1:0]                            total
);
  import fbm_pkg::*;

  logic [TREE_W-1:0] total_next;

  // Add up the lanes
  always_comb begin
    total_next = '0;
    for (int i = 0; i < BLOCK_WIDTH; i++) begin
      total_next = total_next + TREE_W'(terms[i]);
    end
  end

  // Advance the stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  // Hold line total and control
  always_ff @(posedge clk) begin
    if (en) begin
      total <= total_next;
      ctl   <= ctl_in;
    end
  end

endmodule

// File: sv/field_block_metrics.sv
// ----------------------------------------------------------------------------
// field_block_metrics
// Inverse telecine block metric (difference, comb or variation) over an
// 8-wide block, one field line per transaction, one result per block.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                        | per
//  in_ch    | in  | opcode, identical_fields, four 64-bit lines    | line
//  out_ch   | out | metric (15 bits), kind                         | block
//
//  One line per cycle sustained; a line passes lane and merge registers, and
//  the accumulator's block result is registered at the output as its last
//  line leaves merge. Reset (rst, synchronous) empties the pipeline and
//  restarts the block count. A waiting result holds back only the final
//  line of the next block; the lines before it keep flowing, and once that
//  line waits, at most one more line is taken before in_ch.ready drops.
// ----------------------------------------------------------------------------
module field_block_metrics #(
  parameter int BLOCK_WIDTH = fbm_pkg::BLOCK_WIDTH_DEF,
  parameter int BLOCK_LINES = fbm_pkg::BLOCK_LINES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  fbm_in_if.sink    in_ch,
  fbm_out_if.source out_ch
);
  import fbm_pkg::*;

  localparam int CNT_W  = $clog2(BLOCK_LINES);
  localparam int TREE_W = LANE_W + $clog2(BLOCK_WIDTH);
  localparam logic [CNT_W-1:0] LAST_LINE = CNT_W'(BLOCK_LINES - 1);

  // Block tracking at the input
  logic [CNT_W-1:0] line_count;
  kind_t            block_kind;
  logic             block_identical;
  ctl_t             ctl_in;
  logic             in_take;

  // Pipeline stage controls
  logic             v1;
  ctl_t             ctl1;
  logic             en1, en2, acc_take;
  logic             v2;
  ctl_t             ctl2;
  logic [TREE_W-1:0] total2;
  logic [BLOCK_WIDTH-1:0][LANE_W-1:0] terms;

  // Accumulator and result
  logic [SUM_W-1:0] running_sum;
  logic [SUM_W:0]   acc_raw;
  logic [SUM_W-1:0] acc_sat;
  logic [SUM_W+VAR_SHIFT-1:0] scaled;
  logic [SUM_W-1:0] metric_next;
  logic             out_valid;

  // Stall chain: only a last line needs the output slot
  assign acc_take = v2 && (!ctl2.last || !out_valid || out_ch.ready);
  assign en2      = !v2 || acc_take;
  assign en1      = !v1 || en2;
  assign in_ch.ready = en1;
  assign in_take  = in_ch.valid && in_ch.ready;

  // Latch opcode and flag on a block's first line
  always_comb begin
    ctl_in.first = (line_count == '0);
    ctl_in.last  = (line_count == LAST_LINE);
    ctl_in.kind  = ctl_in.first ? in_ch.opcode : block_kind;
    ctl_in.ident = ctl_in.first ? in_ch.identical_fields : block_identical;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count      <= '0;
      block_kind      <= KIND_DIFF;
      block_identical <= 1'b0;
    end else if (in_take) begin
      line_count      <= ctl_in.last ? '0 : line_count + 1'b1;
      block_kind      <= ctl_in.kind;
      block_identical <= ctl_in.ident;
    end
  end

  // Lane stage
  for (genvar j = 0; j < BLOCK_WIDTH; j++) begin : g_lane
    fbm_lane u_lane (
      .clk    (clk),
      .en     (en1),
      .kind   (ctl_in.kind),
      .var_en (!ctl_in.last),
      .a_pix  (in_ch.a_line[PIX_W*j +: PIX_W]),
      .an_pix (in_ch.a_next_line[PIX_W*j +: PIX_W]),
      .bu_pix (in_ch.b_above_line[PIX_W*j +: PIX_W]),
      .b_pix  (in_ch.b_line[PIX_W*j +: PIX_W]),
      .term   (terms[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      ctl1 <= ctl_in;
    end
  end

  // Merge stage
  fbm_merge #(.BLOCK_WIDTH(BLOCK_WIDTH)) u_merge (
    .clk      (clk),
    .rst      (rst),
    .en       (en2),
    .valid_in (v1),
    .ctl_in   (ctl1),
    .terms    (terms),
    .valid    (v2),
    .ctl      (ctl2),
    .total    (total2)
  );

  // Saturating accumulate, restart on a block's first line
  assign acc_raw = (ctl2.first ? '0 : {1'b0, running_sum}) + (SUM_W+1)'(total2);
  assign acc_sat = (acc_raw > {1'b0, SUM_MAX}) ? SUM_MAX : acc_raw[SUM_W-1:0];
  assign scaled  = (SUM_W+VAR_SHIFT)'(acc_sat) << VAR_SHIFT;

  // Scale variation, zero identical fields
  always_comb begin
    metric_next = acc_sat;
    if (ctl2.kind == KIND_VAR) begin
      metric_next = (scaled > (SUM_W+VAR_SHIFT)'(SUM_MAX)) ?
                    SUM_MAX : scaled[SUM_W-1:0];
    end
    if (ctl2.ident) begin
      metric_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_take) begin
      running_sum <= acc_sat;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc_take && ctl2.last) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_take && ctl2.last) begin
      out_ch.metric <= metric_next;
      out_ch.kind   <= ctl2.kind;
    end
  end

  assign out_ch.valid = out_valid;

  // Checks
  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    (acc_take && ctl2.last) |=> out_ch.valid)
    else $error("block end did not produce a result");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    line_count <= LAST_LINE)
    else $error("line count out of range");

  a_var_scaled: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.kind == KIND_VAR) |->
      (out_ch.metric[VAR_SHIFT-1:0] == '0 || out_ch.metric == SUM_MAX))
    else $error("variation metric not scaled");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |-> !(acc_take && ctl2.last))
    else $error("result overwritten while waiting");

endmodule
